### rtl/core/sorted_key_table_assert.svh
// Assertion macros for the sorted key table RTL.
// Used by sorted_key_table.sv; the macros expect clk and arst_n in scope.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define SKT_ASSERT_IMP(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("sorted_key_table: same-cycle check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define SKT_ASSERT_NXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("sorted_key_table: next-cycle check failed");
`else
`define SKT_ASSERT_IMP(label, cond, prop)
`define SKT_ASSERT_NXT(label, cond, prop)
`endif

`endif

### rtl/core/skt_pkg.sv
// Package for the sorted key table: depth, derived widths, codes and beat types.
// Used by skt_cell, skt_ctrl and sorted_key_table; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int SCAN_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_LOOKUP = 2'd2,
		REQ_NONE   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_DUP       = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_APPLY
	} fsm_state_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic signed [31:0] key;
		logic [30:0]        strength;
		logic [30:0]        stock_left;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [30:0] found_strength;
		logic [30:0] found_stock;
		logic [6:0]  entry_count;
	} rsp_t;

	// One table slot as held in a cell.
	typedef struct packed {
		logic               valid;
		logic signed [31:0] key;
		logic [30:0]        strength;
		logic [30:0]        stock;
	} entry_t;

	// Match token that travels down the row during the scan.
	typedef struct packed {
		logic        hit;
		logic [30:0] strength;
		logic [30:0] stock;
	} tok_t;

	// Update command broadcast to every cell on the commit cycle.
	typedef struct packed {
		logic ins;
		logic del;
	} cell_cmd_t;

	// Sequencer outputs.
	typedef struct packed {
		logic busy;
		logic accept;
		logic commit;
	} ctl_t;

endpackage

`default_nettype wire

### rtl/core/skt_cell.sv
// One slot of the sorted row: holds an entry, compares it with the request,
// forwards the match token and shifts toward either neighbor. Uses skt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skt_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  skt_pkg::cell_cmd_t  cmd,
	input  skt_pkg::req_t       req,
	input  skt_pkg::entry_t     prev_ent,
	input  wire                 prev_lt,
	input  skt_pkg::entry_t     next_ent,
	input  skt_pkg::tok_t       tok_in,
	output skt_pkg::entry_t     ent,
	output logic                lt,
	output skt_pkg::tok_t       tok_out
);
	import skt_pkg::*;

	entry_t ent_q;
	entry_t ent_d;
	tok_t   tok_q;
	logic   eq;

	assign lt = ent_q.valid && ($signed(ent_q.key) < $signed(req.key));
	assign eq = ent_q.valid && (ent_q.key == req.key);

	// Entries below the request key stay; the rest open or close the gap.
	always_comb begin
		ent_d = ent_q;
		if (cmd.ins && !lt) begin
			if (prev_lt) begin
				ent_d.valid    = 1'b1;
				ent_d.key      = req.key;
				ent_d.strength = req.strength;
				ent_d.stock    = req.stock_left;
			end else begin
				ent_d = prev_ent;
			end
		end else if (cmd.del && !lt) begin
			ent_d = next_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= ent_d;
		end
	end

	always_ff @(posedge clk) begin
		tok_q.hit      <= tok_in.hit | eq;
		tok_q.strength <= eq ? ent_q.strength : tok_in.strength;
		tok_q.stock    <= eq ? ent_q.stock : tok_in.stock;
	end

	assign ent     = ent_q;
	assign tok_out = tok_q;

endmodule

`default_nettype wire

### rtl/core/skt_ctrl.sv
// Request sequencer: accept, scan the row, then commit once the result register is free.
// Uses skt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skt_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	input  wire            out_free,
	output skt_pkg::ctl_t  ctl
);
	import skt_pkg::*;

	fsm_state_t        state_q;
	fsm_state_t        state_d;
	logic [SCAN_W-1:0] scan_q;
	logic              scan_last;

	assign scan_last = (scan_q == SCAN_W'(TABLE_DEPTH - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (req_valid) begin
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (scan_last) begin
					state_d = FSM_APPLY;
				end
			end
			FSM_APPLY: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			FSM_IDLE: begin
				ctl.accept = req_valid;
			end
			FSM_SCAN: begin
				ctl.busy = 1'b1;
			end
			FSM_APPLY: begin
				ctl.busy   = 1'b1;
				ctl.commit = out_free;
			end
			default: begin
				ctl.busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			scan_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FSM_SCAN) begin
				scan_q <= scan_q + SCAN_W'(1);
			end else begin
				scan_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/sorted_key_table.sv
// Sorted key table top level: request register, row of compare-and-shift cells,
// sequencer and result register. Uses skt_pkg, skt_cell, skt_ctrl and the assert header.
//
//   channel | direction | valid     | stall     | beat type
//   --------+-----------+-----------+-----------+----------------
//   req     | in        | req_valid | req_stall | skt_pkg::req_t
//   rsp     | out       | rsp_valid | rsp_stall | skt_pkg::rsp_t
//
// One request is in work at a time. After its beat is taken the match token ripples
// through the TABLE_DEPTH cells, one cell per cycle, and then the commit applies the
// update once the result register is free.
// Reset empties the table at once; no clearing pass is needed.
// A stalled result holds the commit, and with it the next request; a new request may
// still be taken while the previous result beat waits on rsp_stall.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_table_assert.svh"

module sorted_key_table (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  skt_pkg::req_t  req,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output skt_pkg::rsp_t  rsp
);
	import skt_pkg::*;

	ctl_t             ctl;
	req_t             req_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;
	logic             out_free;
	logic             full;
	logic             hit;
	cell_cmd_t        cmd;

	entry_t ent [TABLE_DEPTH];
	logic   lt  [TABLE_DEPTH];
	tok_t   tok [TABLE_DEPTH];

	// The result register is free when empty or when its beat leaves this cycle.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = ctl.busy;

	skt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.out_free  (out_free),
		.ctl       (ctl)
	);

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			req_q <= req;
		end
	end

	// After the scan the last cell's token holds the match, if any, for the whole row.
	assign hit  = tok[TABLE_DEPTH-1].hit;
	assign full = (count_q == CNT_W'(TABLE_DEPTH));

	// Duplicate rejection comes before the full check; only a real change shifts the row.
	assign cmd.ins = ctl.commit && (req_q.req_type == REQ_INSERT) && !hit && !full;
	assign cmd.del = ctl.commit && (req_q.req_type == REQ_DELETE) && hit;

	// Each cell sees its lower neighbor for inserts and its upper neighbor for
	// deletes. The first cell always counts as the insert point when nothing
	// below it is smaller, and the last cell pulls in an empty slot on a delete.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		entry_t prev_ent;
		entry_t next_ent;
		logic   prev_lt;
		tok_t   tok_in;

		if (i == 0) begin : g_first
			assign prev_ent = '0;
			assign prev_lt  = 1'b1;
			assign tok_in   = '0;
		end else begin : g_mid
			assign prev_ent = ent[i-1];
			assign prev_lt  = lt[i-1];
			assign tok_in   = tok[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign next_ent = '0;
		end else begin : g_inner
			assign next_ent = ent[i+1];
		end

		skt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.req      (req_q),
			.prev_ent (prev_ent),
			.prev_lt  (prev_lt),
			.next_ent (next_ent),
			.tok_in   (tok_in),
			.ent      (ent[i]),
			.lt       (lt[i]),
			.tok_out  (tok[i])
		);
	end

	always_comb begin
		count_d = count_q;
		if (cmd.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.del) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// Result of the committed request; payloads are zero unless a lookup hits.
	always_comb begin
		rsp_d                = '0;
		rsp_d.status         = STAT_OK;
		rsp_d.entry_count    = 7'(count_d);
		unique case (req_q.req_type)
			REQ_INSERT: begin
				if (hit) begin
					rsp_d.status = STAT_DUP;
				end else if (full) begin
					rsp_d.status = STAT_FULL;
				end
			end
			REQ_DELETE: begin
				if (!hit) begin
					rsp_d.status = STAT_NOT_FOUND;
				end
			end
			REQ_LOOKUP: begin
				if (hit) begin
					rsp_d.found_strength = tok[TABLE_DEPTH-1].strength;
					rsp_d.found_stock    = tok[TABLE_DEPTH-1].stock;
				end else begin
					rsp_d.status = STAT_NOT_FOUND;
				end
			end
			REQ_NONE: begin
				rsp_d.status = STAT_OK;
			end
			default: begin
				rsp_d.status = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.commit) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A taken request keeps the input stalled through its scan.
	`SKT_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
	// The held count never exceeds the table depth.
	`SKT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
	// A full rejection only happens with every slot taken.
	`SKT_ASSERT_IMP(a_full_count, rsp_valid && (rsp.status == STAT_FULL),
		count_q == CNT_W'(TABLE_DEPTH))
	// Payloads are only reported on a successful lookup.
	`SKT_ASSERT_IMP(a_payload_zero, rsp_valid && (rsp.status != STAT_OK),
		(rsp.found_strength == 31'd0) && (rsp.found_stock == 31'd0))

endmodule

`default_nettype wire

### tb/sorted_key_table_tb.sv
// Self-checking testbench for sorted_key_table: a request driver, a result monitor
// and a behavioral copy of the ordered table. Depends on skt_pkg and the RTL only.
`timescale 1ns / 1ps

module sorted_key_table_tb;

	import skt_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int KEY_POOL_SIZE = 96;
	localparam int SEGMENT_ITEMS = 50;
	localparam int SEGMENTS = 20;
	localparam int CALM_SEGMENTS = 3;

	// One pending request beat, with the pacing hints for the driver.
	typedef struct {
		req_t beat;
		bit   hold_until_idle;
		bit   gaps_on;
		bit   calm;
	} pending_req_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	pending_req_t pending_reqs[$];
	rsp_t         awaited_rsps[$];

	// Behavioral copy of the table, kept in ascending signed key order.
	int          tbl_key[TABLE_DEPTH];
	logic [30:0] tbl_strength[TABLE_DEPTH];
	logic [30:0] tbl_stock[TABLE_DEPTH];
	int          tbl_count;

	int key_pool[KEY_POOL_SIZE];
	int fail_count;
	int cycle_count;
	int send_gap;
	int stall_left;
	bit stall_mode;
	bit tail_phase;
	bit req_beat_taken;

	sorted_key_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Every failure goes through here: one line per failure, and a count.
	task automatic log_failure(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// Applies one request to the behavioral table and returns the result it must give.
	// The search is linear; the order of the held keys is all that matters here.
	function automatic rsp_t apply_to_table(input req_t r);
		rsp_t res;
		int   k;
		int   pos;
		bit   hit;
		res = '0;
		res.status = STAT_OK;
		k = int'(r.key);
		pos = 0;
		while (pos < tbl_count && tbl_key[pos] < k)
			pos++;
		hit = (pos < tbl_count) && (tbl_key[pos] == k);
		case (r.req_type)
			REQ_INSERT: begin
				// A present key is reported ahead of a full table.
				if (hit) begin
					res.status = STAT_DUP;
				end else if (tbl_count >= TABLE_DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					for (int i = tbl_count; i > pos; i--) begin
						tbl_key[i] = tbl_key[i - 1];
						tbl_strength[i] = tbl_strength[i - 1];
						tbl_stock[i] = tbl_stock[i - 1];
					end
					tbl_key[pos] = k;
					tbl_strength[pos] = r.strength;
					tbl_stock[pos] = r.stock_left;
					tbl_count++;
				end
			end
			REQ_DELETE: begin
				if (!hit) begin
					res.status = STAT_NOT_FOUND;
				end else begin
					for (int i = pos; i + 1 < tbl_count; i++) begin
						tbl_key[i] = tbl_key[i + 1];
						tbl_strength[i] = tbl_strength[i + 1];
						tbl_stock[i] = tbl_stock[i + 1];
					end
					tbl_count--;
				end
			end
			REQ_LOOKUP: begin
				if (!hit) begin
					res.status = STAT_NOT_FOUND;
				end else begin
					res.found_strength = tbl_strength[pos];
					res.found_stock = tbl_stock[pos];
				end
			end
			default: begin
				// The unused request kind changes nothing and reports ok.
			end
		endcase
		res.entry_count = 7'(tbl_count);
		return res;
	endfunction

	function automatic req_t compose_request(input req_kind_t kind, input int k,
			input logic [30:0] s, input logic [30:0] r);
		req_t b;
		b.req_type = kind;
		b.key = k;
		b.strength = s;
		b.stock_left = r;
		return b;
	endfunction

	// Payloads are mostly random, with the extremes now and then.
	function automatic logic [30:0] random_payload();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return 31'($urandom);
	endfunction

	// Keys come mostly from a fixed pool, so that hits, duplicates and a full table
	// are common; the rest are fresh random keys that are nearly always absent.
	function automatic int pick_key();
		if ($urandom_range(0, 9) == 0)
			return int'($urandom);
		return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
	endfunction

	task automatic queue_req(input req_t b, input bit hold_idle, input bit gaps,
			input bit calm);
		pending_req_t p;
		p.beat = b;
		p.hold_until_idle = hold_idle;
		p.gaps_on = gaps;
		p.calm = calm;
		pending_reqs.push_back(p);
	endtask

	// Request driver: a new beat appears only once the previous one was taken,
	// and a beat that waits on req_stall is held unchanged.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_beat_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() == 0 ||
						(pending_reqs[0].hold_until_idle && awaited_rsps.size() != 0)) begin
					req_valid <= 1'b0;
				end else begin
					req <= pending_reqs[0].beat;
					req_valid <= 1'b1;
					if (pending_reqs[0].calm)
						tail_phase <= 1'b1;
					if (pending_reqs[0].gaps_on && !pending_reqs[0].calm &&
							$urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 12);
					void'(pending_reqs.pop_front());
				end
			end
		end
	end

	// Result side back-pressure: bursts of stall, switched on and off in long
	// stretches, and none at all once the calm tail of the run has begun.
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 299) == 0)
				stall_mode = ~stall_mode;
			if (tail_phase) begin
				stall_left = 0;
				rsp_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				if (stall_mode && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 12);
			end
		end
	end

	// Monitor: results are checked against the oldest expectation before the
	// request taken at the same edge adds its own.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			req_beat_taken <= req_valid && !req_stall;
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsps.size() == 0) begin
					log_failure($sformatf("result beat with nothing expected (status %0d)",
						rsp.status));
				end else begin
					want = awaited_rsps.pop_front();
					if (rsp.status != want.status)
						log_failure($sformatf("status %0d, expected %0d",
							rsp.status, want.status));
					if (rsp.found_strength != want.found_strength)
						log_failure($sformatf("found_strength %0d, expected %0d",
							rsp.found_strength, want.found_strength));
					if (rsp.found_stock != want.found_stock)
						log_failure($sformatf("found_stock %0d, expected %0d",
							rsp.found_stock, want.found_stock));
					if (rsp.entry_count != want.entry_count)
						log_failure($sformatf("entry_count %0d, expected %0d",
							rsp.entry_count, want.entry_count));
				end
			end
			if (req_valid && !req_stall)
				awaited_rsps.push_back(apply_to_table(req));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int        mode;
		int        roll;
		bit        calm;
		bit        gaps;
		req_kind_t kind;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		req_beat_taken = 1'b0;
		tail_phase = 1'b0;
		stall_mode = 1'b1;
		send_gap = 0;
		stall_left = 0;
		fail_count = 0;
		cycle_count = 0;
		tbl_count = 0;

		// The pool always holds the key extremes and the values around zero.
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = 0;
		key_pool[3] = -1;
		key_pool[4] = 1;
		for (int i = 5; i < KEY_POOL_SIZE; i++)
			key_pool[i] = int'($urandom);

		// Directed part: empty-table misses, key and payload extremes, a duplicate,
		// hits and misses for lookup and delete, the unused kind, and reinsertion.
		queue_req(compose_request(REQ_LOOKUP, 32'sh8000_0000, '1, '1), 0, 1, 0);
		queue_req(compose_request(REQ_DELETE, 0, '0, '0), 0, 1, 0);
		queue_req(compose_request(REQ_INSERT, 32'sh7fff_ffff, '1, '1), 0, 1, 0);
		queue_req(compose_request(REQ_INSERT, 32'sh8000_0000, '0, '0), 0, 1, 0);
		queue_req(compose_request(REQ_INSERT, 0, 31'h5555_5555, 31'h2aaa_aaaa), 0, 1, 0);
		queue_req(compose_request(REQ_INSERT, -1, 31'h2aaa_aaaa, 31'h5555_5555), 0, 1, 0);
		queue_req(compose_request(REQ_INSERT, 1, '1, '0), 0, 1, 0);
		queue_req(compose_request(REQ_INSERT, 32'sh7fff_ffff, '0, '0), 0, 1, 0);
		queue_req(compose_request(REQ_LOOKUP, 32'sh7fff_ffff, '0, '0), 0, 1, 0);
		queue_req(compose_request(REQ_LOOKUP, 32'sh8000_0000, '1, '1), 0, 1, 0);
		queue_req(compose_request(REQ_LOOKUP, -1, '0, '0), 0, 1, 0);
		queue_req(compose_request(REQ_LOOKUP, 0, '0, '0), 0, 1, 0);
		queue_req(compose_request(REQ_LOOKUP, 12345, '0, '0), 0, 1, 0);
		queue_req(compose_request(REQ_NONE, 32'sh7fff_ffff, '1, '1), 0, 1, 0);
		queue_req(compose_request(REQ_NONE, 0, '0, '0), 0, 1, 0);
		queue_req(compose_request(REQ_DELETE, 32'sh8000_0000, '0, '0), 0, 1, 0);
		queue_req(compose_request(REQ_LOOKUP, 32'sh8000_0000, '0, '0), 0, 1, 0);
		queue_req(compose_request(REQ_DELETE, 12345, '1, '1), 0, 1, 0);
		queue_req(compose_request(REQ_INSERT, 32'sh8000_0000, '1, '1), 0, 1, 0);
		queue_req(compose_request(REQ_DELETE, 32'sh7fff_ffff, '0, '0), 0, 1, 0);
		queue_req(compose_request(REQ_DELETE, -1, '0, '0), 0, 1, 0);
		queue_req(compose_request(REQ_LOOKUP, 1, '0, '0), 0, 1, 0);

		// Random part in segments, each with its own mix: filling (which reaches a
		// full table and duplicates), balanced, draining and lookup-heavy traffic.
		// The first segment always uses the filling mix, so that the table grows early.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			mode = (seg == 0) ? 0 : $urandom_range(0, 3);
			calm = (seg >= SEGMENTS - CALM_SEGMENTS);
			gaps = (seg % 4 != 3);
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					kind = REQ_NONE;
				else if (mode == 0)
					kind = (roll < 85) ? REQ_INSERT : (roll < 93) ? REQ_LOOKUP : REQ_DELETE;
				else if (mode == 1)
					kind = (roll < 40) ? REQ_INSERT : (roll < 70) ? REQ_LOOKUP : REQ_DELETE;
				else if (mode == 2)
					kind = (roll < 20) ? REQ_INSERT : (roll < 35) ? REQ_LOOKUP : REQ_DELETE;
				else
					kind = (roll < 25) ? REQ_INSERT : (roll < 85) ? REQ_LOOKUP : REQ_DELETE;
				// The sender pauses until the block has answered everything
				// at the start of the random part and again halfway through.
				queue_req(compose_request(kind, pick_key(), random_payload(),
					random_payload()), (n == 0) && (seg == 0 || seg == SEGMENTS / 2),
					gaps, calm);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || req_valid)
			@(posedge clk);
		while (awaited_rsps.size() != 0)
			@(posedge clk);
		// One full request time more, so that a stray extra result would be seen.
		repeat (TABLE_DEPTH + 20) @(posedge clk);

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
